// ===== hdl/hca_pkg.sv =====
// Shared types and constants for the HSV color adjustment pipeline.
package hca_pkg;

    localparam int CH_W      = 8;
    localparam int GAIN_W    = 16;
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT   = 8'd3;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd256;

    // Pipelined divider geometry: one quotient bit per stage
    localparam int DIV_NUM_W = 27;
    localparam int DIV_DEN_W = 9;
    localparam int DIV_QUO_W = 18;

    // Edges from request acceptance to the edge that takes the result
    localparam int PIPE_LATENCY = DIV_QUO_W + 11;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
        logic            last_pixel;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic            last_out;
    } t_pix_out;

endpackage

// ===== hdl/hca_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
module hca_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [hca_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [hca_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                           o_valid,
    output logic [hca_pkg::DIV_QUO_W-1:0]  o_quo
);
    import hca_pkg::*;

    logic                 r_vld [DIV_QUO_W];
    logic [DIV_NUM_W-1:0] r_rem [DIV_QUO_W];
    logic [DIV_NUM_W-1:0] n_rem [DIV_QUO_W];
    logic [DIV_DEN_W-1:0] r_den [DIV_QUO_W];
    logic [DIV_DEN_W-1:0] n_den [DIV_QUO_W];
    logic [DIV_QUO_W-1:0] r_quo [DIV_QUO_W];
    logic [DIV_QUO_W-1:0] n_quo [DIV_QUO_W];

    // Each stage tries the divisor shifted to its quotient bit
    always_comb begin
        logic [DIV_NUM_W-1:0] rem_in;
        logic [DIV_NUM_W-1:0] dsh;
        logic [DIV_DEN_W-1:0] den_in;
        logic [DIV_QUO_W-1:0] quo_in;
        for (int s = 0; s < DIV_QUO_W; s++) begin
            if (s == 0) begin
                rem_in = i_num;
                den_in = i_den;
                quo_in = '0;
            end else begin
                rem_in = r_rem[s-1];
                den_in = r_den[s-1];
                quo_in = r_quo[s-1];
            end
            dsh      = DIV_NUM_W'(den_in) << (DIV_QUO_W - 1 - s);
            n_den[s] = den_in;
            if (rem_in >= dsh) begin
                n_rem[s] = rem_in - dsh;
                n_quo[s] = quo_in | (DIV_QUO_W'(1) << (DIV_QUO_W - 1 - s));
            end else begin
                n_rem[s] = rem_in;
                n_quo[s] = quo_in;
            end
        end
    end

    // Valid shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_QUO_W; s++) r_vld[s] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < DIV_QUO_W; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_QUO_W; s++) begin
            r_rem[s] <= n_rem[s];
            r_den[s] <= n_den[s];
            r_quo[s] <= n_quo[s];
        end
    end

    assign o_valid = r_vld[DIV_QUO_W-1];
    assign o_quo   = r_quo[DIV_QUO_W-1];

    // Quotient range fits the stage count: remainder ends below divisor
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_rem[DIV_QUO_W-1] < DIV_NUM_W'(r_den[DIV_QUO_W-1])))
        else $error("divider remainder not below divisor");

endmodule

// ===== hdl/hsv_color_adjust_pixel.sv =====
// Top level: contrast, RGB to HSV, gain, and HSV to RGB pixel pipeline.
// The hue and saturation dividers are pipelined, 18 register stages each.
// Throughput: one pixel per clock; busy is never raised, results cannot be stalled.
// Reset (synchronous, active low): all gains return to 1.0 and every pipeline
//   valid bit clears; data registers are not reset.
module hsv_color_adjust_pixel (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  hca_pkg::t_pix_in               i_pixel,
    output logic                           o_done,
    output hca_pkg::t_pix_out              o_pixel,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [hca_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hca_pkg::GAIN_W-1:0]     i_cfg_data
);
    import hca_pkg::*;

    localparam logic [17:0] TURN_UNITS = 18'd92160;
    localparam logic [29:0] WHOLE      = 30'd1006632960;

    typedef struct packed {
        logic             valid;
        logic [2:0][28:0] num;
        logic             last;
    } t_stg_a;

    typedef struct packed {
        logic            valid;
        logic [2:0][7:0] ch;
        logic            last;
    } t_stg_b;

    typedef struct packed {
        logic                 valid;
        logic [DIV_NUM_W-1:0] hue_num;
        logic [DIV_DEN_W-1:0] hue_den;
        logic [DIV_NUM_W-1:0] sat_num;
        logic [DIV_DEN_W-1:0] sat_den;
        logic [7:0]           mx;
        logic                 last;
    } t_stg_c;

    typedef struct packed {
        logic [7:0] mx;
        logic       last;
    } t_side;

    typedef struct packed {
        logic        valid;
        logic [16:0] hue;
        logic [16:0] sat;
        logic [15:0] val;
        logic        last;
    } t_stg_d;

    typedef struct packed {
        logic        valid;
        logic [24:0] hue;
        logic [16:0] sat;
        logic [15:0] val;
        logic        last;
    } t_stg_e;

    typedef struct packed {
        logic        valid;
        logic [30:0] yprod;
        logic [14:0] y;
        logic [9:0]  lo;
        logic [16:0] sat;
        logic [15:0] val;
        logic        last;
    } t_stg_f;

    typedef struct packed {
        logic        valid;
        logic [2:0]  sector;
        logic [13:0] fr;
        logic [16:0] sat;
        logic [15:0] val;
        logic        last;
    } t_stg_g;

    typedef struct packed {
        logic             valid;
        logic [2:0]       sector;
        logic [2:0][29:0] nums;   // p, q, t numerators
        logic [15:0]      val;
        logic             last;
    } t_stg_h;

    typedef struct packed {
        logic             valid;
        logic [2:0]       sector;
        logic [2:0][45:0] prod;
        logic [7:0]       cv;
        logic             last;
    } t_stg_i;

    typedef struct packed {
        logic            valid;
        logic [2:0]      sector;
        logic [2:0]      big;
        logic [2:0][7:0] q8;
        logic [7:0]      cv;
        logic            last;
    } t_stg_j;

    logic [GAIN_W-1:0] r_contrast, r_hue, r_sat, r_bright;

    t_stg_a r_a, n_a;
    t_stg_b r_b, n_b;
    t_stg_c r_c, n_c;
    t_side  r_side [DIV_QUO_W];
    t_stg_d r_d, n_d;
    t_stg_e r_e, n_e;
    t_stg_f r_f, n_f;
    t_stg_g r_g, n_g;
    t_stg_h r_h, n_h;
    t_stg_i r_i, n_i;
    t_stg_j r_j, n_j;
    t_pix_out r_out, n_out;
    logic     r_done;

    logic                 div_hue_vld, div_sat_vld;
    logic [DIV_QUO_W-1:0] div_hue_quo, div_sat_quo;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_pixel     = r_out;

    // Gain registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_contrast <= GAIN_ONE;
            r_hue      <= GAIN_ONE;
            r_sat      <= GAIN_ONE;
            r_bright   <= GAIN_ONE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CONTRAST: r_contrast <= i_cfg_data;
                CFG_HUE:      r_hue      <= i_cfg_data;
                CFG_SAT:      r_sat      <= i_cfg_data;
                CFG_BRIGHT:   r_bright   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage A: contrast numerator 256*sum + (3*ch - sum)*gain
    always_comb begin
        logic [9:0]         sum;
        logic [9:0]         ch3;
        logic signed [11:0] d;
        logic signed [28:0] mul;
        logic [7:0]         chs [3];
        chs[0] = i_pixel.red_in;
        chs[1] = i_pixel.green_in;
        chs[2] = i_pixel.blue_in;
        sum = 10'(chs[0]) + 10'(chs[1]) + 10'(chs[2]);
        n_a.valid = start && !busy;
        n_a.last  = i_pixel.last_pixel;
        for (int k = 0; k < 3; k++) begin
            ch3 = 10'(chs[k]) * 10'd3;
            d   = $signed({2'b0, ch3}) - $signed({2'b0, sum});
            mul = $signed(29'(d)) * $signed({13'b0, r_contrast});
            n_a.num[k] = mul + $signed({11'b0, sum, 8'b0});
        end
    end

    // Stage B: round by 768 and clamp
    always_comb begin
        logic signed [28:0] num;
        logic [28:0]        w;
        logic [19:0]        p;
        n_b.valid = r_a.valid;
        n_b.last  = r_a.last;
        for (int k = 0; k < 3; k++) begin
            num = $signed(r_a.num[k]);
            w   = r_a.num[k] + 29'd384;
            p   = 20'(w[17:8]) * 20'd683;
            if (num[28] || num == 29'sd0) begin
                n_b.ch[k] = 8'd0;
            end else if (w >= 29'd196608) begin
                n_b.ch[k] = 8'd255;
            end else begin
                n_b.ch[k] = p[18:11];
            end
        end
    end

    // Stage C: max, min, hue base and divider operands
    always_comb begin
        logic [7:0]  r, g, b, mx, mn, delta;
        logic [11:0] base;
        logic        zero;
        r = r_b.ch[0];
        g = r_b.ch[1];
        b = r_b.ch[2];
        mx = (r > g) ? r : g;
        if (b > mx) mx = b;
        mn = (r < g) ? r : g;
        if (b < mn) mn = b;
        delta = mx - mn;
        zero  = (delta == 8'd0);
        // ties: red over green over blue
        priority if (r == mx) begin
            base = 12'(g) + 12'(delta) * 12'd6 - 12'(b);
        end else if (g == mx) begin
            base = 12'(delta) * 12'd8 + 12'(b) - 12'(r);
        end else begin
            base = 12'(delta) * 12'd10 + 12'(r) - 12'(g);
        end
        n_c.valid   = r_b.valid;
        n_c.last    = r_b.last;
        n_c.mx      = mx;
        n_c.hue_num = zero ? '0 : (DIV_NUM_W'(base) << 15) - (DIV_NUM_W'(base) << 11)
                                  + DIV_NUM_W'(delta);
        n_c.hue_den = zero ? DIV_DEN_W'(1) : {delta, 1'b0};
        n_c.sat_num = zero ? '0 : (DIV_NUM_W'(delta) << 17) + DIV_NUM_W'(mx);
        n_c.sat_den = zero ? DIV_DEN_W'(1) : {mx, 1'b0};
    end

    hca_div u_div_hue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_c.valid),
        .i_num   (r_c.hue_num),
        .i_den   (r_c.hue_den),
        .o_valid (div_hue_vld),
        .o_quo   (div_hue_quo)
    );

    hca_div u_div_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_c.valid),
        .i_num   (r_c.sat_num),
        .i_den   (r_c.sat_den),
        .o_valid (div_sat_vld),
        .o_quo   (div_sat_quo)
    );

    // Side data alongside the dividers
    always_ff @(posedge i_clk) begin
        r_side[0] <= '{mx: r_c.mx, last: r_c.last};
        for (int s = 1; s < DIV_QUO_W; s++) r_side[s] <= r_side[s-1];
    end

    // Stage D: hue wrap, value gain
    always_comb begin
        logic [23:0] v;
        v = 24'(r_side[DIV_QUO_W-1].mx) * 24'(r_bright);
        n_d.valid = div_hue_vld;
        n_d.last  = r_side[DIV_QUO_W-1].last;
        n_d.hue   = (div_hue_quo >= TURN_UNITS) ? 17'(div_hue_quo - TURN_UNITS)
                                                : 17'(div_hue_quo);
        n_d.sat   = 17'(div_sat_quo);
        n_d.val   = (v > 24'd65280) ? 16'd65280 : v[15:0];
    end

    // Stage E: hue and saturation gains
    always_comb begin
        logic [33:0] hp, sp;
        hp = 34'(r_d.hue) * 34'(r_hue) + 34'd128;
        sp = 34'(r_d.sat) * 34'(r_sat) + 34'd128;
        n_e.valid = r_d.valid;
        n_e.last  = r_d.last;
        n_e.val   = r_d.val;
        n_e.hue   = hp[32:8];
        n_e.sat   = (sp[33:8] > 26'd65536) ? 17'd65536 : sp[24:8];
    end

    // Stage F: sector by 15360 = 1024 * 15, reciprocal of 15
    always_comb begin
        n_f.valid = r_e.valid;
        n_f.last  = r_e.last;
        n_f.sat   = r_e.sat;
        n_f.val   = r_e.val;
        n_f.y     = r_e.hue[24:10];
        n_f.lo    = r_e.hue[9:0];
        n_f.yprod = 31'(r_e.hue[24:10]) * 31'd34953;
    end

    // Stage G: sector index and fraction
    always_comb begin
        logic [11:0] nq;
        logic [14:0] rem;
        nq  = r_f.yprod[30:19];
        rem = r_f.y - 15'(nq) * 15'd15;
        n_g.valid  = r_f.valid;
        n_g.last   = r_f.last;
        n_g.sat    = r_f.sat;
        n_g.val    = r_f.val;
        n_g.fr     = {rem[3:0], r_f.lo};
        // sectors past the last use the last row
        n_g.sector = (nq > 12'd5) ? 3'd5 : nq[2:0];
    end

    // Stage H: p, q, t numerators over 65536*15360
    always_comb begin
        logic [30:0] sf, sg;
        sf = 31'(r_g.sat) * 31'(r_g.fr);
        sg = 31'(r_g.sat) * 31'(14'd15360 - r_g.fr);
        n_h.valid   = r_g.valid;
        n_h.last    = r_g.last;
        n_h.sector  = r_g.sector;
        n_h.val     = r_g.val;
        n_h.nums[0] = 30'(17'd65536 - r_g.sat) * 30'd15360;
        n_h.nums[1] = 30'(31'(WHOLE) - sf);
        n_h.nums[2] = 30'(31'(WHOLE) - sg);
    end

    // Stage I: scale by value
    always_comb begin
        logic [15:0] vs;
        vs = r_h.val + 16'd128;
        n_i.valid  = r_h.valid;
        n_i.last   = r_h.last;
        n_i.sector = r_h.sector;
        n_i.cv     = vs[15:8];
        for (int k = 0; k < 3; k++) begin
            n_i.prod[k] = 46'(r_h.val) * 46'(r_h.nums[k]);
        end
    end

    // Stage J: round over 2^34 * 15, reciprocal of 15
    always_comb begin
        logic [46:0] zs;
        logic [12:0] z;
        logic [25:0] zm;
        n_j.valid  = r_i.valid;
        n_j.last   = r_i.last;
        n_j.sector = r_i.sector;
        n_j.cv     = r_i.cv;
        for (int k = 0; k < 3; k++) begin
            zs = 47'(r_i.prod[k]) + (47'd15 << 33);
            z  = zs[46:34];
            zm = 26'(z[11:0]) * 26'd8739;
            n_j.big[k] = (z >= 13'd3840);
            n_j.q8[k]  = zm[24:17];
        end
    end

    // Stage K: clamp and sector table
    always_comb begin
        logic [7:0] cp, cq, ct, cv;
        cp = r_j.big[0] ? 8'd255 : r_j.q8[0];
        cq = r_j.big[1] ? 8'd255 : r_j.q8[1];
        ct = r_j.big[2] ? 8'd255 : r_j.q8[2];
        cv = r_j.cv;
        n_out.last_out = r_j.last;
        unique case (r_j.sector)
            3'd0: begin
                n_out.red_out = cv; n_out.green_out = ct; n_out.blue_out = cp;
            end
            3'd1: begin
                n_out.red_out = cq; n_out.green_out = cv; n_out.blue_out = cp;
            end
            3'd2: begin
                n_out.red_out = cp; n_out.green_out = cv; n_out.blue_out = ct;
            end
            3'd3: begin
                n_out.red_out = cp; n_out.green_out = cq; n_out.blue_out = cv;
            end
            3'd4: begin
                n_out.red_out = ct; n_out.green_out = cp; n_out.blue_out = cv;
            end
            default: begin
                n_out.red_out = cv; n_out.green_out = cp; n_out.blue_out = cq;
            end
        endcase
    end

    // Pipeline registers: payload free running, valid bits reset
    always_ff @(posedge i_clk) begin
        r_a.num <= n_a.num;  r_a.last <= n_a.last;
        r_b.ch  <= n_b.ch;   r_b.last <= n_b.last;
        r_c.hue_num <= n_c.hue_num;
        r_c.hue_den <= n_c.hue_den;
        r_c.sat_num <= n_c.sat_num;
        r_c.sat_den <= n_c.sat_den;
        r_c.mx      <= n_c.mx;
        r_c.last    <= n_c.last;
        r_d.hue <= n_d.hue;  r_d.sat <= n_d.sat;
        r_d.val <= n_d.val;  r_d.last <= n_d.last;
        r_e.hue <= n_e.hue;  r_e.sat <= n_e.sat;
        r_e.val <= n_e.val;  r_e.last <= n_e.last;
        r_f.yprod <= n_f.yprod; r_f.y <= n_f.y; r_f.lo <= n_f.lo;
        r_f.sat   <= n_f.sat;   r_f.val <= n_f.val; r_f.last <= n_f.last;
        r_g.sector <= n_g.sector; r_g.fr <= n_g.fr; r_g.sat <= n_g.sat;
        r_g.val    <= n_g.val;    r_g.last <= n_g.last;
        r_h.sector <= n_h.sector; r_h.nums <= n_h.nums;
        r_h.val    <= n_h.val;    r_h.last <= n_h.last;
        r_i.sector <= n_i.sector; r_i.prod <= n_i.prod;
        r_i.cv     <= n_i.cv;     r_i.last <= n_i.last;
        r_j.sector <= n_j.sector; r_j.big <= n_j.big; r_j.q8 <= n_j.q8;
        r_j.cv     <= n_j.cv;     r_j.last <= n_j.last;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_b.valid <= 1'b0;
            r_c.valid <= 1'b0;
            r_d.valid <= 1'b0;
            r_e.valid <= 1'b0;
            r_f.valid <= 1'b0;
            r_g.valid <= 1'b0;
            r_h.valid <= 1'b0;
            r_i.valid <= 1'b0;
            r_j.valid <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_a.valid <= n_a.valid;
            r_b.valid <= n_b.valid;
            r_c.valid <= n_c.valid;
            r_d.valid <= n_d.valid;
            r_e.valid <= n_e.valid;
            r_f.valid <= n_f.valid;
            r_g.valid <= n_g.valid;
            r_h.valid <= n_h.valid;
            r_i.valid <= n_i.valid;
            r_j.valid <= n_j.valid;
            r_done    <= r_j.valid;
        end
    end

    // Every accepted request yields a strobe after the full pipeline depth
    a_req_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LATENCY o_done)
        else $error("accepted request produced no result strobe");

    // Both dividers march in lockstep
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_hue_vld == div_sat_vld)
        else $error("hue and saturation dividers out of step");

    // Wrapped hue stays inside one turn
    a_hue_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d.valid |-> (18'(r_d.hue) < TURN_UNITS))
        else $error("hue not wrapped into one turn");

    // Sector split gives a legal row and a fraction under one sector
    a_sector_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_g.valid |-> (r_g.sector <= 3'd5 && r_g.fr < 14'd15360))
        else $error("bad sector or fraction");

endmodule
